[rtl/chd_pkg.sv]
// ----------------------------------------------------------------------------
// chd_pkg
// Shared constants, angle table and item class type for the compass heading
// core.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int AXIS_WIDTH_DEF   = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  // angle format: degrees with ANGLE_FRAC fraction bits
  localparam int ANGLE_FRAC  = 20;
  localparam int ANG_W       = 30;
  // magnitudes enter the rotator moved left by PRE_SHIFT; GUARD_BITS cover growth
  localparam int PRE_SHIFT   = 24;
  localparam int GUARD_BITS  = 3;
  localparam int TABLE_LEN   = 24;
  localparam int HEAD_W      = 9;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [ANG_W-1:0] DEG_45  = 30'sd47185920;   // PI/4
  localparam logic signed [ANG_W-1:0] DEG_90  = 30'sd94371840;   // PI/2
  localparam logic signed [ANG_W-1:0] DEG_180 = 30'sd188743680;  // PI
  localparam logic signed [ANG_W-1:0] DEG_360 = 30'sd377487360;  // 2*PI

  // atan(2^-i) in degrees, scaled by 2^ANGLE_FRAC
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
    30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
    30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
    30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
    30'sd917,      30'sd458,      30'sd229,      30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  // classification of one item, made by the front end
  typedef struct packed {
    logic                    use_cordic;  // angle comes from the rotator
    logic                    x_neg;
    logic                    y_neg;
    logic                    b_zero;      // |y| is zero
    logic signed [ANG_W-1:0] phi_spec;    // fixed angle for special cases
  } chd_class_t;

endpackage

[rtl/compass_heading_degrees_core.sv]
// ----------------------------------------------------------------------------
// compass_heading_degrees_core
// Clockwise compass heading in whole degrees from a magnetometer x/y sample.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   sample   | push_i / full_o    | field_x_i, field_y_i (signed)
//   heading  | pop_i  / empty_o   | heading_deg_o (0..359, unsigned)
//
// One item per cycle sustained while results are popped. From push the
// result passes through the front queue, each rotation stage register
// and the result register before it shows. Reset clears queue pointers,
// the item count and the stage and result valid bits only; no clearing pass.
// When the result is not popped the rotator pipeline holds; the front queue
// (QUEUE_DEPTH items) keeps taking samples until it fills and raises full_o.
//
module compass_heading_degrees_core
  import chd_pkg::*;
#(
  parameter int AXIS_WIDTH   = AXIS_WIDTH_DEF,
  parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample side
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [AXIS_WIDTH-1:0] field_x_i,
  input  logic [AXIS_WIDTH-1:0] field_y_i,
  // heading side
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [HEAD_W-1:0]     heading_deg_o
);

  logic                  q_valid, q_pop;
  logic [AXIS_WIDTH-1:0] mag_a, mag_b;
  chd_class_t            cls;

  // front: magnitudes, signs, special cases (axis hits, diagonal), queue
  chd_front #(
    .AXIS_WIDTH (AXIS_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .field_x_i (field_x_i),
    .field_y_i (field_y_i),
    .full_o    (full_o),
    .deq_i     (q_pop),
    .q_valid_o (q_valid),
    .mag_a_o   (mag_a),
    .mag_b_o   (mag_b),
    .cls_o     (cls)
  );

  // back: unrolled vectoring rotator, quadrant fix-up, result register
  chd_back #(
    .AXIS_WIDTH   (AXIS_WIDTH),
    .ANGLE_STAGES (ANGLE_STAGES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .mag_a_i       (mag_a),
    .mag_b_i       (mag_b),
    .cls_i         (cls),
    .q_pop_o       (q_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .heading_deg_o (heading_deg_o)
  );

endmodule

[rtl/chd_front.sv]
// ----------------------------------------------------------------------------
// chd_front
// Accepts samples, takes magnitudes and signs, sorts out the special cases
// and holds classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module chd_front
  import chd_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [AXIS_WIDTH-1:0] field_x_i,
  input  logic [AXIS_WIDTH-1:0] field_y_i,
  output logic                  full_o,
  input  logic                  deq_i,
  output logic                  q_valid_o,
  output logic [AXIS_WIDTH-1:0] mag_a_o,
  output logic [AXIS_WIDTH-1:0] mag_b_o,
  output chd_class_t            cls_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [AXIS_WIDTH-1:0] mag_a, mag_b;
  logic                  x_neg, y_neg;
  chd_class_t            cls;

  logic [AXIS_WIDTH-1:0] a_mem [QUEUE_DEPTH];
  logic [AXIS_WIDTH-1:0] b_mem [QUEUE_DEPTH];
  chd_class_t            c_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  do_push, do_pop;

  // most negative input negates to itself, which is the right magnitude
  always_comb begin
    x_neg = field_x_i[AXIS_WIDTH-1];
    y_neg = field_y_i[AXIS_WIDTH-1];
    mag_a = x_neg ? (~field_x_i + 1'b1) : field_x_i;
    mag_b = y_neg ? (~field_y_i + 1'b1) : field_y_i;
  end

  always_comb begin
    cls.x_neg      = x_neg;
    cls.y_neg      = y_neg;
    cls.b_zero     = (mag_b == '0);
    cls.use_cordic = 1'b0;
    priority if (mag_b == '0) begin
      cls.phi_spec = '0;
    end else if (mag_a == '0) begin
      cls.phi_spec = DEG_90;
    end else if (mag_a == mag_b) begin
      cls.phi_spec = DEG_45;
    end else begin
      cls.phi_spec   = '0;
      cls.use_cordic = 1'b1;
    end
  end

  assign full_o    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign q_valid_o = (count_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = deq_i && q_valid_o;

  assign mag_a_o = a_mem[rd_ptr_q];
  assign mag_b_o = b_mem[rd_ptr_q];
  assign cls_o   = c_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      a_mem[wr_ptr_q] <= mag_a;
      b_mem[wr_ptr_q] <= mag_b;
      c_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

[rtl/chd_stage.sv]
// ----------------------------------------------------------------------------
// chd_stage
// One vectoring rotation step with its pipeline register.
// ----------------------------------------------------------------------------
module chd_stage
  import chd_pkg::*;
#(
  parameter int XY_W  = AXIS_WIDTH_DEF + PRE_SHIFT + GUARD_BITS,
  parameter int STAGE = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [XY_W-1:0]  y_i,
  input  logic signed [ANG_W-1:0] z_i,
  input  chd_class_t              cls_i,
  output logic                    valid_o,
  output logic signed [XY_W-1:0]  x_o,
  output logic signed [XY_W-1:0]  y_o,
  output logic signed [ANG_W-1:0] z_o,
  output chd_class_t              cls_o
);

  logic                    valid_q;
  logic signed [XY_W-1:0]  x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ANG_W-1:0] z_q, z_d;
  chd_class_t              cls_q;

  // arithmetic shift floors, as the angle table assumes
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!y_i[XY_W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_TAB[STAGE];
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      cls_q <= cls_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign cls_o   = cls_q;

endmodule

[rtl/chd_back.sv]
// ----------------------------------------------------------------------------
// chd_back
// Rotator pipeline, quadrant placement and the result register.
// ----------------------------------------------------------------------------
module chd_back
  import chd_pkg::*;
#(
  parameter int AXIS_WIDTH   = AXIS_WIDTH_DEF,
  parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [AXIS_WIDTH-1:0] mag_a_i,
  input  logic [AXIS_WIDTH-1:0] mag_b_i,
  input  chd_class_t            cls_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [HEAD_W-1:0]     heading_deg_o
);

  localparam int XY_W = AXIS_WIDTH + PRE_SHIFT + GUARD_BITS;

  logic                    en;
  logic                    valid_s [ANGLE_STAGES+1];
  logic signed [XY_W-1:0]  x_s     [ANGLE_STAGES+1];
  logic signed [XY_W-1:0]  y_s     [ANGLE_STAGES+1];
  logic signed [ANG_W-1:0] z_s     [ANGLE_STAGES+1];
  chd_class_t              cls_s   [ANGLE_STAGES+1];

  logic signed [ANG_W-1:0] z_end, phi, h_raw, h_wrap;
  chd_class_t              cls_end;
  logic                    out_valid_q;
  logic [HEAD_W-1:0]       heading_q, heading_d;

  // whole pipeline moves unless a result is held and not taken
  assign en      = !out_valid_q || pop_i;
  assign q_pop_o = en && q_valid_i;

  assign valid_s[0] = q_valid_i;
  assign x_s[0]     = signed'({{GUARD_BITS{1'b0}}, mag_a_i, {PRE_SHIFT{1'b0}}});
  assign y_s[0]     = signed'({{GUARD_BITS{1'b0}}, mag_b_i, {PRE_SHIFT{1'b0}}});
  assign z_s[0]     = '0;
  assign cls_s[0]   = cls_i;

  for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_stage
    chd_stage #(
      .XY_W  (XY_W),
      .STAGE (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[g]),
      .x_i     (x_s[g]),
      .y_i     (y_s[g]),
      .z_i     (z_s[g]),
      .cls_i   (cls_s[g]),
      .valid_o (valid_s[g+1]),
      .x_o     (x_s[g+1]),
      .y_o     (y_s[g+1]),
      .z_o     (z_s[g+1]),
      .cls_o   (cls_s[g+1])
    );
  end

  assign z_end   = z_s[ANGLE_STAGES];
  assign cls_end = cls_s[ANGLE_STAGES];

  // clamp to the first quadrant, then place by the signs
  always_comb begin
    if (!cls_end.use_cordic) begin
      phi = cls_end.phi_spec;
    end else if (z_end[ANG_W-1]) begin
      phi = '0;
    end else if (z_end > DEG_90) begin
      phi = DEG_90;
    end else begin
      phi = z_end;
    end

    unique case ({cls_end.x_neg, cls_end.y_neg || cls_end.b_zero})
      2'b01:   h_raw = phi;
      2'b00:   h_raw = DEG_360 - phi;
      2'b11:   h_raw = DEG_180 - phi;
      default: h_raw = DEG_180 + phi;
    endcase

    h_wrap = (h_raw >= DEG_360) ? h_raw - DEG_360 : h_raw;
    if (h_wrap[ANG_W-1]) begin
      h_wrap = '0;
    end
    heading_d = h_wrap[ANGLE_FRAC +: HEAD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[ANGLE_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      heading_q <= heading_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign heading_deg_o = heading_q;

endmodule
